// ===== rtl/asmtok_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asmtok_pkg: shared types and constants of the assembly opcode tokenizer
// Request and token structs, token kinds, scanner state codes and the
// keyword tail table.
// ----------------------------------------------------------------------------
package asmtok_pkg;

    typedef struct packed {
        logic [7:0] char_code;
        logic       end_of_input;
    } t_in_req;

    typedef struct packed {
        logic [2:0]  token_kind;
        logic [30:0] token_value;
        logic        last_of_run;
    } t_out_tok;

    // Token kinds
    localparam logic [2:0] KIND_INSTR   = 3'd0;
    localparam logic [2:0] KIND_REG     = 3'd1;
    localparam logic [2:0] KIND_CONST   = 3'd2;
    localparam logic [2:0] KIND_COMMA   = 3'd3;
    localparam logic [2:0] KIND_ARROW   = 3'd4;
    localparam logic [2:0] KIND_END     = 3'd5;
    localparam logic [2:0] KIND_INVALID = 3'd6;

    // Opcodes
    localparam logic [3:0] OP_LOAD   = 4'd0;
    localparam logic [3:0] OP_LOADI  = 4'd1;
    localparam logic [3:0] OP_LSHIFT = 4'd6;
    localparam logic [3:0] OP_RSHIFT = 4'd7;

    // Scanner state codes
    localparam logic [5:0] MODE_START   = 6'd0;
    localparam logic [5:0] MODE_COMMENT = 6'd1;
    localparam logic [5:0] MODE_DROP    = 6'd2;
    localparam logic [5:0] MODE_AFTER_L = 6'd3;
    localparam logic [5:0] MODE_AFTER_S = 6'd4;
    localparam logic [5:0] MODE_AFTER_R = 6'd5;
    localparam logic [5:0] MODE_REG     = 6'd6;
    localparam logic [5:0] MODE_CONST   = 6'd7;
    localparam logic [5:0] MODE_EQ      = 6'd8;
    localparam logic [5:0] MODE_LOADT   = 6'd9;
    localparam logic [5:0] MODE_MATCH   = 6'd16;
    localparam logic [5:0] MATCH_LEN    = 6'd22;

    // Offsets into the keyword tail table
    localparam logic [5:0] TAIL_OAD    = 6'd0;
    localparam logic [5:0] TAIL_HIFT   = 6'd2;
    localparam logic [5:0] TAIL_TORE   = 6'd6;
    localparam logic [5:0] TAIL_UB     = 6'd9;
    localparam logic [5:0] TAIL_ULT    = 6'd10;
    localparam logic [5:0] TAIL_DD     = 6'd13;
    localparam logic [5:0] TAIL_OP     = 6'd15;
    localparam logic [5:0] TAIL_UTPUT  = 6'd17;

    // Finish codes of the tail table; other values are opcodes
    localparam logic [3:0] FIN_NONE  = 4'd15;
    localparam logic [3:0] FIN_LOAD  = 4'd14;
    localparam logic [3:0] FIN_SHIFT = 4'd13;

    // Characters
    localparam logic [7:0] CH_LF    = 8'd10;
    localparam logic [7:0] CH_SLASH = 8'h2F;
    localparam logic [7:0] CH_EQ    = 8'h3D;
    localparam logic [7:0] CH_GT    = 8'h3E;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_CAP_I = 8'h49;
    localparam logic [7:0] CH_ZERO  = 8'h30;

    // Expected character at each position of the tails
    // "ad" "hift" "ore" "b" "ult" "dd" "op" "utput"
    function automatic logic [7:0] tail_char(input logic [4:0] idx);
        logic [7:0] ch;
        case (idx)
            5'd0:    ch = "a";
            5'd1:    ch = "d";
            5'd2:    ch = "h";
            5'd3:    ch = "i";
            5'd4:    ch = "f";
            5'd5:    ch = "t";
            5'd6:    ch = "o";
            5'd7:    ch = "r";
            5'd8:    ch = "e";
            5'd9:    ch = "b";
            5'd10:   ch = "u";
            5'd11:   ch = "l";
            5'd12:   ch = "t";
            5'd13:   ch = "d";
            5'd14:   ch = "d";
            5'd15:   ch = "o";
            5'd16:   ch = "p";
            5'd17:   ch = "u";
            5'd18:   ch = "t";
            5'd19:   ch = "p";
            5'd20:   ch = "u";
            5'd21:   ch = "t";
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    function automatic logic [3:0] tail_finish(input logic [4:0] idx);
        logic [3:0] fin;
        case (idx)
            5'd1:    fin = FIN_LOAD;
            5'd5:    fin = FIN_SHIFT;
            5'd8:    fin = 4'd2;   // store
            5'd9:    fin = 4'd4;   // sub
            5'd12:   fin = 4'd5;   // mult
            5'd14:   fin = 4'd3;   // add
            5'd16:   fin = 4'd9;   // nop
            5'd21:   fin = 4'd8;   // output
            default: fin = FIN_NONE;
        endcase
        return fin;
    endfunction

endpackage

// ===== rtl/asm_opcode_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// asm_opcode_tokenizer: streaming lexer for a small three-address assembly
// Takes one source byte (or an end marker) per request and emits zero, one
// or two tokens per request.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_valid / o_ready, payload i_in) carries one byte or an
//   end-of-text marker per request. Output channel (o_valid / i_ready,
//   payload o_out) carries tokens; last_of_run flags the final token that a
//   request produced. Requests that yield no token (whitespace, comments,
//   dropped bytes) produce nothing on the output.
//   An accepted request sits in the input register and is scanned from
//   there; its tokens land in the result buffer, from which the first
//   token is visible.
//   Throughput: one request per cycle while the result buffer has room for
//   its tokens. A request that yields two tokens fills the two-entry result
//   buffer, which sets the rate whenever such requests come in a row.
//   Reset clears the scanner to the between-tokens state and empties both
//   the input register and the result buffer. An end marker also returns the
//   scanner to that state, so a new text can follow at once.
//   When the receiver stalls, tokens hold in the result buffer; once it is
//   full the input register holds its request and o_ready drops.
// ----------------------------------------------------------------------------
module asm_opcode_tokenizer #(
    parameter int VALUE_BITS = 31
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  asmtok_pkg::t_in_req   i_in,
    output logic                  o_valid,
    input  logic                  i_ready,
    output asmtok_pkg::t_out_tok  o_out
);
    import asmtok_pkg::*;

    localparam int SUM_BITS = VALUE_BITS + 4;

    typedef struct packed {
        logic [5:0] mode;
        logic       emit;
        logic [2:0] kind;
        logic       load_digit;
    } t_start;

    // Decode of a byte scanned from the between-tokens state
    function automatic t_start scan_start(input logic [7:0] c);
        t_start s;
        s.mode       = MODE_START;
        s.emit       = 1'b0;
        s.kind       = KIND_INVALID;
        s.load_digit = 1'b0;
        case (c) inside
            8'h20, [8'd9:8'd13]: ;
            [8'h30:8'h39]: begin
                s.mode       = MODE_CONST;
                s.load_digit = 1'b1;
            end
            CH_SLASH: s.mode = MODE_COMMENT;
            "l":      s.mode = MODE_AFTER_L;
            "s":      s.mode = MODE_AFTER_S;
            "r":      s.mode = MODE_AFTER_R;
            "m":      s.mode = MODE_MATCH + TAIL_ULT;
            "a":      s.mode = MODE_MATCH + TAIL_DD;
            "n":      s.mode = MODE_MATCH + TAIL_OP;
            "o":      s.mode = MODE_MATCH + TAIL_UTPUT;
            CH_EQ:    s.mode = MODE_EQ;
            CH_COMMA: begin
                s.emit = 1'b1;
                s.kind = KIND_COMMA;
            end
            default:  s.emit = 1'b1;
        endcase
        return s;
    endfunction

    // Input register
    logic    r_in_valid;
    t_in_req r_in;

    // Scanner state
    logic [5:0]            r_mode, n_mode;
    logic                  r_shr, n_shr;
    logic [VALUE_BITS-1:0] r_acc, n_acc;

    // Result buffer
    t_out_tok   r_buf [2];
    t_out_tok   n_buf [2];
    logic [1:0] r_cnt, n_cnt;

    // Scan results
    logic [2:0]  tk_kind [2];
    logic [30:0] tk_val  [2];
    logic [1:0]  ntok;

    logic [7:0]            c;
    logic [3:0]            digit;
    logic                  is_digit;
    logic [SUM_BITS-1:0]   acc_sum;
    logic [VALUE_BITS-1:0] acc_sat;
    logic [30:0]           acc_tok;
    logic [4:0]            tidx;
    logic [3:0]            tfin;
    logic                  in_match;
    t_start                st;
    logic                  do_start;
    logic                  sslot;

    logic       pop, proc;
    logic [1:0] rem;

    assign c        = r_in.char_code;
    assign digit    = 4'(c - CH_ZERO);
    assign is_digit = (c >= "0") && (c <= "9");
    assign st       = scan_start(c);
    assign tidx     = 5'(r_mode - MODE_MATCH);
    assign tfin     = tail_finish(tidx);
    assign in_match = (r_mode >= MODE_MATCH) && (r_mode < MODE_MATCH + MATCH_LEN);

    // acc * 10 + digit, saturated to all ones
    assign acc_sum = (SUM_BITS'(r_acc) << 3) + (SUM_BITS'(r_acc) << 1) + SUM_BITS'(digit);
    assign acc_sat = (acc_sum[SUM_BITS-1:VALUE_BITS] != '0) ? '1 : acc_sum[VALUE_BITS-1:0];
    assign acc_tok = 31'(32'(r_acc));

    always_comb begin
        n_mode     = r_mode;
        n_shr      = r_shr;
        n_acc      = r_acc;
        tk_kind[0] = KIND_INVALID;
        tk_kind[1] = KIND_INVALID;
        tk_val[0]  = '0;
        tk_val[1]  = '0;
        ntok       = 2'd0;
        do_start   = 1'b0;
        sslot      = 1'b0;

        if (r_in.end_of_input) begin
            // Flush a pending token, then the end token; reset the scanner
            ntok = 2'd1;
            if (r_mode == MODE_REG || r_mode == MODE_CONST) begin
                tk_kind[0] = (r_mode == MODE_REG) ? KIND_REG : KIND_CONST;
                tk_val[0]  = acc_tok;
                ntok       = 2'd2;
            end else if (r_mode == MODE_LOADT) begin
                tk_kind[0] = KIND_INSTR;
                tk_val[0]  = 31'(OP_LOAD);
                ntok       = 2'd2;
            end else if (r_mode != MODE_START && r_mode != MODE_COMMENT &&
                         r_mode != MODE_DROP) begin
                tk_kind[0] = KIND_INVALID;
                ntok       = 2'd2;
            end
            tk_kind[ntok[1]] = KIND_END;
            tk_val[ntok[1]]  = '0;
            n_mode = MODE_START;
            n_shr  = 1'b0;
            n_acc  = '0;
        end else if (in_match) begin
            if (c != tail_char(tidx)) begin
                do_start = 1'b1;
                sslot    = 1'b1;
            end else if (tfin == FIN_NONE) begin
                n_mode = r_mode + 6'd1;
            end else if (tfin == FIN_LOAD) begin
                n_mode = MODE_LOADT;
            end else begin
                tk_kind[0] = KIND_INSTR;
                tk_val[0]  = (tfin == FIN_SHIFT) ?
                             31'(r_shr ? OP_RSHIFT : OP_LSHIFT) : 31'(tfin);
                ntok       = 2'd1;
                n_mode     = MODE_DROP;
            end
        end else begin
            unique case (r_mode) inside
                MODE_COMMENT: begin
                    if (c == CH_LF) begin
                        n_mode = MODE_START;
                    end
                end
                MODE_DROP: n_mode = MODE_START;
                MODE_AFTER_L: begin
                    if (c == "o") begin
                        n_mode = MODE_MATCH + TAIL_OAD;
                    end else if (c == "s") begin
                        n_shr  = 1'b0;
                        n_mode = MODE_MATCH + TAIL_HIFT;
                    end else begin
                        do_start = 1'b1;
                        sslot    = 1'b1;
                    end
                end
                MODE_AFTER_S: begin
                    if (c == "t") begin
                        n_mode = MODE_MATCH + TAIL_TORE;
                    end else if (c == "u") begin
                        n_mode = MODE_MATCH + TAIL_UB;
                    end else begin
                        do_start = 1'b1;
                        sslot    = 1'b1;
                    end
                end
                MODE_AFTER_R: begin
                    if (is_digit) begin
                        n_acc  = VALUE_BITS'(digit);
                        n_mode = MODE_REG;
                    end else if (c == "s") begin
                        n_shr  = 1'b1;
                        n_mode = MODE_MATCH + TAIL_HIFT;
                    end else begin
                        do_start = 1'b1;
                        sslot    = 1'b1;
                    end
                end
                MODE_REG, MODE_CONST: begin
                    if (is_digit) begin
                        n_acc = acc_sat;
                    end else begin
                        // Number ends: emit it, then rescan this byte
                        tk_kind[0] = (r_mode == MODE_REG) ? KIND_REG : KIND_CONST;
                        tk_val[0]  = acc_tok;
                        do_start   = 1'b1;
                        sslot      = 1'b1;
                        ntok       = 2'd1;
                    end
                end
                MODE_EQ: begin
                    if (c == CH_GT) begin
                        tk_kind[0] = KIND_ARROW;
                        ntok       = 2'd1;
                        n_mode     = MODE_START;
                    end else begin
                        do_start = 1'b1;
                        sslot    = 1'b1;
                    end
                end
                MODE_LOADT: begin
                    tk_kind[0] = KIND_INSTR;
                    ntok       = 2'd1;
                    if (c == CH_CAP_I) begin
                        tk_val[0] = 31'(OP_LOADI);
                        n_mode    = MODE_DROP;
                    end else begin
                        tk_val[0] = 31'(OP_LOAD);
                        n_mode    = MODE_START;
                    end
                end
                default: do_start = 1'b1;
            endcase
        end

        // A failed match or an ended number emits invalid or the number first
        if (do_start) begin
            if (sslot && ntok == 2'd0) begin
                tk_kind[0] = KIND_INVALID;
                tk_val[0]  = '0;
            end
            n_mode = st.mode;
            if (st.load_digit) begin
                n_acc = VALUE_BITS'(digit);
            end
            if (st.emit) begin
                tk_kind[sslot] = st.kind;
                tk_val[sslot]  = '0;
            end
            ntok = 2'(sslot) + 2'(st.emit);
        end
    end

    // Result buffer: pop from the head, append the new tokens behind what stays
    assign pop     = (r_cnt != 2'd0) && i_ready;
    assign rem     = r_cnt - 2'(pop);
    assign proc    = r_in_valid && ((2'd2 - rem) >= ntok);
    assign o_ready = !r_in_valid || proc;
    assign o_valid = (r_cnt != 2'd0);
    assign o_out   = r_buf[0];

    always_comb begin
        logic [1:0] pos;
        pos      = 2'd0;
        n_buf[0] = r_buf[0];
        n_buf[1] = r_buf[1];
        if (pop) begin
            n_buf[0] = r_buf[1];
        end
        n_cnt = rem;
        if (proc) begin
            for (int i = 0; i < 2; i++) begin
                pos = rem + 2'(i);
                if (2'(i) < ntok) begin
                    n_buf[pos[0]].token_kind  = tk_kind[i];
                    n_buf[pos[0]].token_value = tk_val[i];
                    n_buf[pos[0]].last_of_run = (2'(i) == ntok - 2'd1);
                end
            end
            n_cnt = rem + ntok;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_cnt      <= 2'd0;
            r_mode     <= MODE_START;
            r_shr      <= 1'b0;
            r_acc      <= '0;
        end else begin
            r_cnt <= n_cnt;
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            // Advance the scanner only when the request's tokens fit
            if (proc) begin
                r_mode <= n_mode;
                r_shr  <= n_shr;
                r_acc  <= n_acc;
            end
        end
    end

    // Payload registers: no reset
    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in <= i_in;
        end
        r_buf[0] <= n_buf[0];
        r_buf[1] <= n_buf[1];
    end

endmodule

// ===== tb/sv/tb_asm_opcode_tokenizer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_asm_opcode_tokenizer: self-checking bench for the assembly tokenizer
// Walks a short directed table, then streams generated assembly text (mostly
// well-formed lines, some noise, broken keywords and end markers) through the
// byte channel. A built-in lexer predicts every token; tokens are matched in
// order against the result channel while both sides idle at random.
// ----------------------------------------------------------------------------
module tb_asm_opcode_tokenizer;
    import asmtok_pkg::*;

    // Opcodes that the package does not name
    localparam logic [3:0] OP_STORE  = 4'd2;
    localparam logic [3:0] OP_ADD    = 4'd3;
    localparam logic [3:0] OP_SUB    = 4'd4;
    localparam logic [3:0] OP_MULT   = 4'd5;
    localparam logic [3:0] OP_OUTPUT = 4'd8;
    localparam logic [3:0] OP_NOP    = 4'd9;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;

    localparam int          VALUE_BITS   = 31;
    localparam logic [63:0] VALUE_MAX    = (64'd1 << VALUE_BITS) - 64'd1;
    localparam int          PHASE_REQS   = 485;
    localparam int          HOLD_CYCLES  = 150;
    localparam int          DRAIN_CYCLES = 20;
    localparam int unsigned CYCLE_LIMIT  = 400000;

    logic     i_clk   = 1'b0;
    logic     i_rst_n = 1'b0;
    logic     i_valid = 1'b0;
    logic     o_ready;
    t_in_req  i_in    = '0;
    logic     o_valid;
    logic     i_ready = 1'b0;
    t_out_tok o_out;

    asm_opcode_tokenizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_in    (i_in),
        .o_valid (o_valid),
        .i_ready (i_ready),
        .o_out   (o_out)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Token predictor: a software lexer with its own scanner state
    // ------------------------------------------------------------------------
    logic [5:0]  lx_mode  = MODE_START;
    logic        lx_right = 1'b0;
    logic [63:0] lx_acc   = '0;

    // Keyword tails laid end to end, indexed by mode minus MODE_MATCH
    string kw_tails = "adhiftorebultddoputput";

    t_out_tok step_toks[$];      // tokens caused by the request being scanned
    t_out_tok tok_expect_q[$];   // tokens still owed by the block

    // Finish code at a tail position: the last letter of each tail ends a
    // keyword, every other letter just advances
    function automatic logic [3:0] kw_finish(input logic [5:0] idx);
        logic [3:0] fin;
        fin = FIN_NONE;
        if (idx == TAIL_HIFT - 1)       fin = FIN_LOAD;
        else if (idx == TAIL_TORE - 1)  fin = FIN_SHIFT;
        else if (idx == TAIL_UB - 1)    fin = OP_STORE;
        else if (idx == TAIL_ULT - 1)   fin = OP_SUB;
        else if (idx == TAIL_DD - 1)    fin = OP_MULT;
        else if (idx == TAIL_OP - 1)    fin = OP_ADD;
        else if (idx == TAIL_UTPUT - 1) fin = OP_NOP;
        else if (idx == MATCH_LEN - 1)  fin = OP_OUTPUT;
        return fin;
    endfunction

    function automatic logic is_num(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void emit_tok(input logic [2:0] kind, input logic [63:0] val);
        t_out_tok t;
        t.token_kind  = kind;
        t.token_value = val[30:0];
        t.last_of_run = 1'b0;
        step_toks.push_back(t);
    endfunction

    // Shift in one decimal digit, clamp at the largest value
    function automatic void add_digit(input logic [7:0] c);
        logic [63:0] sum;
        sum    = lx_acc * 64'd10 + 64'(c - CH_ZERO);
        lx_acc = (sum > VALUE_MAX) ? VALUE_MAX : sum;
    endfunction

    // Scan a byte from the between-tokens state
    function automatic void lex_begin(input logic [7:0] c);
        lx_mode = MODE_START;
        if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
            return;
        if (is_num(c)) begin
            lx_acc = '0;
            add_digit(c);
            lx_mode = MODE_CONST;
            return;
        end
        case (c)
            CH_SLASH: lx_mode = MODE_COMMENT;
            "l":      lx_mode = MODE_AFTER_L;
            "s":      lx_mode = MODE_AFTER_S;
            "r":      lx_mode = MODE_AFTER_R;
            "m":      lx_mode = MODE_MATCH + TAIL_ULT;
            "a":      lx_mode = MODE_MATCH + TAIL_DD;
            "n":      lx_mode = MODE_MATCH + TAIL_OP;
            "o":      lx_mode = MODE_MATCH + TAIL_UTPUT;
            CH_EQ:    lx_mode = MODE_EQ;
            CH_COMMA: emit_tok(KIND_COMMA, '0);
            default:  emit_tok(KIND_INVALID, '0);
        endcase
    endfunction

    // Broken prefix: flag it, then rescan the offending byte
    function automatic void lex_fail(input logic [7:0] c);
        emit_tok(KIND_INVALID, '0);
        lex_begin(c);
    endfunction

    function automatic void lex_char(input logic [7:0] c);
        logic [5:0] idx;
        logic [3:0] fin;
        if (lx_mode >= MODE_MATCH && lx_mode < MODE_MATCH + MATCH_LEN) begin
            idx = lx_mode - MODE_MATCH;
            if (c != 8'(kw_tails[idx])) begin
                lex_fail(c);
                return;
            end
            fin = kw_finish(idx);
            if (fin == FIN_NONE) begin
                lx_mode = lx_mode + 6'd1;
            end else if (fin == FIN_LOAD) begin
                lx_mode = MODE_LOADT;
            end else begin
                if (fin == FIN_SHIFT)
                    fin = lx_right ? OP_RSHIFT : OP_LSHIFT;
                emit_tok(KIND_INSTR, 64'(fin));
                lx_mode = MODE_DROP;
            end
            return;
        end
        case (lx_mode) inside
            MODE_COMMENT: begin
                if (c == CH_LF)
                    lx_mode = MODE_START;
            end
            MODE_DROP: lx_mode = MODE_START;
            MODE_AFTER_L: begin
                if (c == "o") begin
                    lx_mode = MODE_MATCH + TAIL_OAD;
                end else if (c == "s") begin
                    lx_right = 1'b0;
                    lx_mode  = MODE_MATCH + TAIL_HIFT;
                end else begin
                    lex_fail(c);
                end
            end
            MODE_AFTER_S: begin
                if (c == "t")
                    lx_mode = MODE_MATCH + TAIL_TORE;
                else if (c == "u")
                    lx_mode = MODE_MATCH + TAIL_UB;
                else
                    lex_fail(c);
            end
            MODE_AFTER_R: begin
                if (is_num(c)) begin
                    lx_acc = '0;
                    add_digit(c);
                    lx_mode = MODE_REG;
                end else if (c == "s") begin
                    lx_right = 1'b1;
                    lx_mode  = MODE_MATCH + TAIL_HIFT;
                end else begin
                    lex_fail(c);
                end
            end
            MODE_REG, MODE_CONST: begin
                if (is_num(c)) begin
                    add_digit(c);
                end else begin
                    emit_tok((lx_mode == MODE_REG) ? KIND_REG : KIND_CONST, lx_acc);
                    lex_begin(c);
                end
            end
            MODE_EQ: begin
                if (c == CH_GT) begin
                    emit_tok(KIND_ARROW, '0);
                    lx_mode = MODE_START;
                end else begin
                    lex_fail(c);
                end
            end
            MODE_LOADT: begin
                if (c == CH_CAP_I) begin
                    emit_tok(KIND_INSTR, 64'(OP_LOADI));
                    lx_mode = MODE_DROP;
                end else begin
                    emit_tok(KIND_INSTR, 64'(OP_LOAD));
                    lx_mode = MODE_START;
                end
            end
            default: lex_begin(c);
        endcase
    endfunction

    // End marker: flush whatever token is open, then emit end and clear state
    function automatic void lex_end();
        if (lx_mode == MODE_REG)
            emit_tok(KIND_REG, lx_acc);
        else if (lx_mode == MODE_CONST)
            emit_tok(KIND_CONST, lx_acc);
        else if (lx_mode == MODE_LOADT)
            emit_tok(KIND_INSTR, 64'(OP_LOAD));
        else if (lx_mode != MODE_START && lx_mode != MODE_COMMENT && lx_mode != MODE_DROP)
            emit_tok(KIND_INVALID, '0);
        emit_tok(KIND_END, '0);
        lx_mode  = MODE_START;
        lx_right = 1'b0;
        lx_acc   = '0;
    endfunction

    // Predict the tokens of one request into step_toks, flag the last one
    function automatic void lex_request(input t_in_req r);
        t_out_tok t;
        step_toks.delete();
        if (r.end_of_input)
            lex_end();
        else
            lex_char(r.char_code);
        if (step_toks.size() > 0) begin
            t = step_toks.pop_back();
            t.last_of_run = 1'b1;
            step_toks.push_back(t);
        end
    endfunction

    // ------------------------------------------------------------------------
    // Source text generator
    // ------------------------------------------------------------------------
    t_in_req src_q[$];

    function automatic string kw_text(input logic [3:0] op);
        case (op)
            OP_LOAD:   return "load";
            OP_LOADI:  return "loadI";
            OP_STORE:  return "store";
            OP_ADD:    return "add";
            OP_SUB:    return "sub";
            OP_MULT:   return "mult";
            OP_LSHIFT: return "lshift";
            OP_RSHIFT: return "rshift";
            OP_OUTPUT: return "output";
            default:   return "nop";
        endcase
    endfunction

    function automatic void put_char(input logic [7:0] c);
        t_in_req r;
        r.char_code    = c;
        r.end_of_input = 1'b0;
        src_q.push_back(r);
    endfunction

    // The byte under an end marker is ignored; randomize it anyway
    function automatic void put_end();
        t_in_req r;
        r.char_code    = 8'($urandom_range(255));
        r.end_of_input = 1'b1;
        src_q.push_back(r);
    endfunction

    function automatic void put_text(input string s);
        for (int k = 0; k < s.len(); k++)
            put_char(8'(s[k]));
    endfunction

    function automatic void put_gap();
        put_char($urandom_range(1) ? CH_SPACE : 8'(CH_TAB + $urandom_range(4)));
    endfunction

    // Mostly short numbers; now and then long enough to saturate
    function automatic void put_number(input logic as_reg);
        int ndig;
        ndig = ($urandom_range(7) == 0) ? $urandom_range(8, 12) : $urandom_range(1, 3);
        if (as_reg)
            put_char("r");
        repeat (ndig)
            put_char(8'("0" + $urandom_range(9)));
    endfunction

    function automatic void put_prefix();
        string s;
        s = kw_text(4'($urandom_range(9)));
        put_text(s.substr(0, $urandom_range(0, s.len() - 2)));
    endfunction

    // Append one chunk of text: an instruction line, noise, a broken token
    // or an end marker (possibly right inside a token)
    function automatic void gen_chunk();
        int pick;
        int n_opnd;
        pick = $urandom_range(99);
        if (pick < 65) begin
            put_text(kw_text(4'($urandom_range(9))));
            put_gap();
            n_opnd = $urandom_range(0, 3);
            for (int k = 0; k < n_opnd; k++) begin
                if (k > 0) begin
                    put_char(CH_COMMA);
                    if ($urandom_range(1))
                        put_gap();
                end
                put_number($urandom_range(3) != 0);
            end
            if ($urandom_range(1)) begin
                if ($urandom_range(1))
                    put_gap();
                put_char(CH_EQ);
                put_char(CH_GT);
                put_gap();
                put_number(1'b1);
            end
            if ($urandom_range(3) == 0) begin
                put_char(CH_SLASH);
                put_char(CH_SLASH);
                repeat ($urandom_range(0, 6))
                    put_char(8'($urandom_range(255)));
            end
            if ($urandom_range(24) == 0)
                put_end();
            else
                put_char(CH_LF);
        end else if (pick < 78) begin
            repeat ($urandom_range(1, 5))
                put_char(8'($urandom_range(255)));
        end else if (pick < 92) begin
            case ($urandom_range(2))
                0:       put_prefix();
                1:       put_char(CH_EQ);
                default: put_char("r");
            endcase
            put_char(($urandom_range(1)) ? 8'($urandom_range(255)) : CH_SPACE);
        end else begin
            case ($urandom_range(6))
                0: put_prefix();
                1: put_text("load");
                2: put_number(1'b0);
                3: put_number(1'b1);
                4: put_char("r");
                5: put_char(CH_EQ);
                default: put_char(CH_SLASH);
            endcase
            put_end();
        end
    endfunction

    // ------------------------------------------------------------------------
    // Result side: random ready, one long hold-off on request, token check
    // ------------------------------------------------------------------------
    int          rcv_idle_pct = 0;
    int          snd_idle_pct = 0;
    int          stall_ask    = 0;
    int          stall_seen   = 0;
    int          hold_left    = 0;
    int          mismatch_cnt = 0;
    int unsigned cyc_cnt      = 0;

    always @(posedge i_clk) begin
        t_out_tok want;
        if (i_rst_n && o_valid && i_ready) begin
            if (tok_expect_q.size() == 0) begin
                $display("%0t: unexpected token: expected none, got kind %0d value %0d last %0d",
                         $time, o_out.token_kind, o_out.token_value, o_out.last_of_run);
                mismatch_cnt++;
            end else begin
                want = tok_expect_q.pop_front();
                if (o_out.token_kind != want.token_kind ||
                    o_out.token_value != want.token_value ||
                    o_out.last_of_run != want.last_of_run) begin
                    $display("%0t: expected kind %0d value %0d last %0d, got %0d %0d %0d",
                             $time, want.token_kind, want.token_value, want.last_of_run,
                             o_out.token_kind, o_out.token_value, o_out.last_of_run);
                    mismatch_cnt++;
                end
            end
        end
        // Start a long hold-off when the stimulus asks for one
        if (stall_seen != stall_ask) begin
            stall_seen = stall_ask;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_ready <= 1'b0;
        end else begin
            i_ready <= ($urandom_range(99) >= rcv_idle_pct);
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cyc_cnt <= cyc_cnt + 1;
        if (cyc_cnt == CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------

    // Offer one request, wait for the handshake, then log the tokens it owes.
    // Keep valid high across back-to-back requests; drop it only for a gap.
    task automatic offer_req(input t_in_req r, input logic typed, input t_out_tok typed_tok);
        if ($urandom_range(99) < snd_idle_pct) begin
            i_valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle_pct);
        end
        i_in    <= r;
        i_valid <= 1'b1;
        do @(posedge i_clk); while (!o_ready);
        lex_request(r);
        if (typed) begin
            // Hand-written expectation stands in for the prediction
            typed_tok.last_of_run = 1'b1;
            tok_expect_q.push_back(typed_tok);
        end else begin
            foreach (step_toks[k])
                tok_expect_q.push_back(step_toks[k]);
        end
    endtask

    task automatic run_phase(input int snd_pct, input int rcv_pct, input int n_reqs);
        snd_idle_pct = snd_pct;
        rcv_idle_pct <= rcv_pct;
        repeat (n_reqs) begin
            if (src_q.size() == 0)
                gen_chunk();
            offer_req(src_q.pop_front(), 1'b0, '0);
        end
    endtask

    // Directed table: byte, end marker, typed flag, then the one token that a
    // typed row must yield. Untyped rows go to the predictor.
    typedef struct packed {
        logic [7:0]  ch;
        logic        eoi;
        logic        typed;
        logic [2:0]  kind;
        logic [30:0] val;
    } t_dir_row;

    t_dir_row dir_rows [0:24] = '{
        {8'hA5,    1'b1, 1'b1, KIND_END,     31'd0},            // end right after reset
        {8'h00,    1'b0, 1'b1, KIND_INVALID, 31'd0},            // lowest byte
        {8'hFF,    1'b0, 1'b1, KIND_INVALID, 31'd0},            // highest byte
        {CH_COMMA, 1'b0, 1'b1, KIND_COMMA,   31'd0},
        {"l",      1'b0, 1'b0, KIND_INSTR,   31'd0},
        {"o",      1'b0, 1'b0, KIND_INSTR,   31'd0},
        {"a",      1'b0, 1'b0, KIND_INSTR,   31'd0},
        {"d",      1'b0, 1'b0, KIND_INSTR,   31'd0},
        {"x",      1'b0, 1'b1, KIND_INSTR,   31'(OP_LOAD)},     // load, tail byte dropped
        {"l",      1'b0, 1'b0, KIND_INSTR,   31'd0},
        {"o",      1'b0, 1'b0, KIND_INSTR,   31'd0},
        {"a",      1'b0, 1'b0, KIND_INSTR,   31'd0},
        {"d",      1'b0, 1'b0, KIND_INSTR,   31'd0},
        {CH_CAP_I, 1'b0, 1'b1, KIND_INSTR,   31'(OP_LOADI)},
        {CH_SPACE, 1'b0, 1'b0, KIND_INSTR,   31'd0},            // dropped after loadI
        {"r",      1'b0, 1'b0, KIND_INSTR,   31'd0},
        {"7",      1'b0, 1'b0, KIND_INSTR,   31'd0},
        {CH_EQ,    1'b0, 1'b0, KIND_INSTR,   31'd0},            // ends the register
        {CH_GT,    1'b0, 1'b1, KIND_ARROW,   31'd0},
        {CH_SLASH, 1'b0, 1'b0, KIND_INSTR,   31'd0},
        {CH_LF,    1'b0, 1'b0, KIND_INSTR,   31'd0},            // closes the comment
        {"a",      1'b0, 1'b0, KIND_INSTR,   31'd0},
        {8'h3C,    1'b1, 1'b0, KIND_INSTR,   31'd0},            // end inside a keyword
        {"9",      1'b0, 1'b0, KIND_INSTR,   31'd0},
        {8'h00,    1'b1, 1'b0, KIND_INSTR,   31'd0}             // end inside a constant
    };

    initial begin
        t_in_req  r;
        t_out_tok tok;

        // Hold reset low at the start, then release it
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed table under light sender idling and heavy receiver idling
        snd_idle_pct = 19;
        rcv_idle_pct <= 82;
        foreach (dir_rows[k]) begin
            r.char_code       = dir_rows[k].ch;
            r.end_of_input    = dir_rows[k].eoi;
            tok.token_kind    = dir_rows[k].kind;
            tok.token_value   = dir_rows[k].val;
            tok.last_of_run   = 1'b0;
            offer_req(r, dir_rows[k].typed, tok);
        end

        run_phase(19, 82, PHASE_REQS);
        run_phase(82, 19, PHASE_REQS);
        // Stall the receiver for a long stretch while requests keep coming,
        // so the result buffer fills and the input backs up
        stall_ask <= stall_ask + 1;
        run_phase(0, 0, PHASE_REQS);

        // Drop valid right at the last handshake so the request is not resent
        i_valid <= 1'b0;
        while (tok_expect_q.size() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (mismatch_cnt == 0 && tok_expect_q.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
